/* src/mcm_pkg.sv */
`timescale 1ns / 1ps

package mcm_pkg;

    // Item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_EVENT = 1'b1;

    // MIDI message kinds
    localparam logic [1:0] KIND_OTHER    = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd2;
    localparam logic [1:0] KIND_CC       = 2'd3;

    // Mapping modes
    localparam logic [1:0] MODE_BUTTON   = 2'd0;
    localparam logic [1:0] MODE_ABSOLUTE = 2'd1;
    localparam logic [1:0] MODE_REL_TWOS = 2'd2;
    localparam logic [1:0] MODE_REL_OFS  = 2'd3;

    // Configuration register indexes
    localparam logic REG_ENTRIES_IN_USE = 1'b0;
    localparam logic REG_PICKUP_TOL     = 1'b1;

    localparam logic [15:0] TOL_RESET = 16'd1311;
    localparam logic [16:0] ONE_Q15   = 17'd32768;
    localparam logic [6:0]  RAW_FULL  = 7'd127;

    typedef struct packed {
        logic               func;
        logic [3:0]         slot;
        logic [1:0]         kind;
        logic [4:0]         channel;
        logic [6:0]         number;
        logic [6:0]         raw_value;
        logic [15:0]        current_value;
        logic [1:0]         map_mode;
        logic               map_inverted;
        logic signed [15:0] map_minimum;
        logic signed [15:0] map_maximum;
        logic [7:0]         param_id;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         target_param;
        logic signed [15:0] target_value;
    } t_out_item;

    typedef struct packed {
        logic [4:0]         channel;
        logic [6:0]         number;
        logic               is_note;
        logic [1:0]         mode;
        logic               inverted;
        logic signed [15:0] minimum;
        logic signed [15:0] maximum;
        logic [7:0]         param;
    } t_map_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_NORM,
        ST_MUL,
        ST_SCALE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic read;
        logic next;
        logic norm;
        logic mul;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic event_go;
        logic match;
        logic last;
        logic blocked;
        logic out_free;
    } t_dp_status;

    // round(a * 32768 / 127) for |a| <= 128, as 258*|a| + (2*|a| + 63) / 127
    function automatic logic signed [17:0] to_q15(input logic signed [7:0] a);
        logic [7:0]  mag;
        logic [9:0]  v;
        logic [17:0] q;
        mag = a[7] ? 8'(-a) : 8'(a);
        v   = {1'b0, mag, 1'b0} + 10'd63;
        q   = 18'(mag) * 18'd258;
        if (v >= 10'd254) begin
            q = q + 18'd2;
        end else if (v >= 10'd127) begin
            q = q + 18'd1;
        end
        return a[7] ? $signed(-q) : $signed(q);
    endfunction

endpackage

/* src/mcm_ctrl.sv */
`timescale 1ns / 1ps

module mcm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mcm_pkg::t_dp_status i_status,
    output mcm_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_stall
);

    mcm_pkg::t_state r_state;
    mcm_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcm_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.event_go) begin
                    n_state = mcm_pkg::ST_READ;
                end
            end
            mcm_pkg::ST_READ: begin
                n_state = mcm_pkg::ST_CHECK;
            end
            mcm_pkg::ST_CHECK: begin
                if (i_status.match) begin
                    n_state = mcm_pkg::ST_NORM;
                end else if (i_status.last) begin
                    n_state = mcm_pkg::ST_IDLE;
                end else begin
                    n_state = mcm_pkg::ST_READ;
                end
            end
            mcm_pkg::ST_NORM: begin
                n_state = i_status.blocked ? mcm_pkg::ST_IDLE : mcm_pkg::ST_MUL;
            end
            mcm_pkg::ST_MUL: begin
                n_state = mcm_pkg::ST_SCALE;
            end
            mcm_pkg::ST_SCALE: begin
                if (i_status.out_free) begin
                    n_state = mcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcm_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            mcm_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                o_cmd.start  = i_in_valid && i_status.event_go;
            end
            mcm_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
            end
            mcm_pkg::ST_CHECK: begin
                o_cmd.next = !i_status.match && !i_status.last;
            end
            mcm_pkg::ST_NORM: begin
                o_cmd.norm = !i_status.blocked;
            end
            mcm_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            mcm_pkg::ST_SCALE: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* src/mcm_datapath.sv */
`timescale 1ns / 1ps

module mcm_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcm_pkg::t_in_item   i_in_item,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_wr_data,
    input  mcm_pkg::t_dp_cmd    i_cmd,
    output mcm_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mcm_pkg::t_out_item  o_out_item
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [4:0]               r_entries_in_use;
    logic [15:0]              r_pickup_tol;
    mcm_pkg::t_map_entry      r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   r_flags;
    logic [CW-1:0]            r_idx;
    logic [4:0]               r_chan;
    logic [6:0]               r_num;
    logic                     r_is_note;
    logic [6:0]               r_raw;
    logic [15:0]              r_cur;
    mcm_pkg::t_map_entry      r_ent;
    logic                     r_flag;
    logic [15:0]              r_n;
    logic signed [16:0]       r_diff;
    logic signed [33:0]       r_prod;
    logic                     r_out_valid;
    mcm_pkg::t_out_item       r_out_item;

    logic [CW-1:0]            count_eff;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    mcm_pkg::t_map_entry      wr_entry;
    logic                     in_is_note;
    logic [15:0]              n_abs;
    logic signed [7:0]        delta;
    logic signed [17:0]       rel_q;
    logic signed [18:0]       rel_sum;
    logic [15:0]              n_rel;
    logic signed [17:0]       pick_d;
    logic [16:0]              pick_mag;
    logic [15:0]              n_sel;
    logic [15:0]              n_fin;
    logic                     set_flag;
    logic signed [34:0]       rounded;
    logic signed [34:0]       scaled;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= 5'd0;
            r_pickup_tol     <= mcm_pkg::TOL_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mcm_pkg::REG_ENTRIES_IN_USE: r_entries_in_use <= i_cfg_wr_data[4:0];
                mcm_pkg::REG_PICKUP_TOL:     r_pickup_tol     <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp search bound to table depth
    always_comb begin
        if (32'(r_entries_in_use) > TABLE_DEPTH) begin
            count_eff = CW'(TABLE_DEPTH);
        end else begin
            count_eff = CW'(r_entries_in_use);
        end
    end

    assign in_is_note = (i_in_item.kind == mcm_pkg::KIND_NOTE_ON) ||
                        (i_in_item.kind == mcm_pkg::KIND_NOTE_OFF);

    // Load item decode
    assign wr_en   = i_cmd.accept && (i_in_item.func == mcm_pkg::FUNC_LOAD) &&
                     (32'(i_in_item.slot) < TABLE_DEPTH);
    assign wr_addr = AW'(i_in_item.slot);
    assign rd_addr = r_idx[AW-1:0];

    always_comb begin
        wr_entry.channel  = i_in_item.channel;
        wr_entry.number   = i_in_item.number;
        wr_entry.is_note  = in_is_note;
        wr_entry.mode     = i_in_item.map_mode;
        wr_entry.inverted = i_in_item.map_inverted;
        wr_entry.minimum  = i_in_item.map_minimum;
        wr_entry.maximum  = i_in_item.map_maximum;
        wr_entry.param    = i_in_item.param_id;
    end

    // Mapping table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_entry;
        end
        if (i_cmd.read) begin
            r_ent <= r_mem[rd_addr];
        end
    end

    // Pickup flags: clear on load, set on first pickup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            if (wr_en) begin
                r_flags[wr_addr] <= 1'b0;
            end
            if (i_cmd.norm && set_flag) begin
                r_flags[rd_addr] <= 1'b1;
            end
        end
    end

    // Capture event and walk slot index
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_chan    <= i_in_item.channel;
            r_num     <= i_in_item.number;
            r_is_note <= in_is_note;
            r_cur     <= i_in_item.current_value;
            if (in_is_note) begin
                r_raw <= (i_in_item.kind == mcm_pkg::KIND_NOTE_ON) ? mcm_pkg::RAW_FULL : 7'd0;
            end else begin
                r_raw <= i_in_item.raw_value;
            end
        end
        if (i_cmd.read) begin
            r_flag <= r_flags[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.start) begin
            r_idx <= '0;
        end else if (i_cmd.next) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    // Normalize according to mode
    always_comb begin
        n_abs = 16'(mcm_pkg::to_q15($signed({1'b0, r_raw})));
        if (r_ent.mode == mcm_pkg::MODE_REL_TWOS) begin
            delta = $signed({r_raw[6], r_raw});
        end else begin
            delta = $signed({1'b0, r_raw}) - 8'sd64;
        end
        rel_q   = mcm_pkg::to_q15(delta);
        rel_sum = $signed({3'b000, r_cur}) + 19'(rel_q);
        if (rel_sum < 0) begin
            n_rel = 16'd0;
        end else if (rel_sum > $signed({2'b00, mcm_pkg::ONE_Q15})) begin
            n_rel = 16'(mcm_pkg::ONE_Q15);
        end else begin
            n_rel = rel_sum[15:0];
        end
        pick_d   = $signed({2'b00, n_abs}) - $signed({2'b00, r_cur});
        pick_mag = pick_d[17] ? 17'(-pick_d) : pick_d[16:0];
        case (r_ent.mode)
            mcm_pkg::MODE_BUTTON:   n_sel = (r_raw != 7'd0) ? 16'(mcm_pkg::ONE_Q15) : 16'd0;
            mcm_pkg::MODE_ABSOLUTE: n_sel = n_abs;
            default:                n_sel = n_rel;
        endcase
        n_fin    = r_ent.inverted ? 16'(mcm_pkg::ONE_Q15 - {1'b0, n_sel}) : n_sel;
        set_flag = (r_ent.mode == mcm_pkg::MODE_ABSOLUTE) && !r_flag;
    end

    // Hold normalized value and span, then multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.norm) begin
            r_n    <= n_fin;
            r_diff <= $signed({r_ent.maximum[15], r_ent.maximum}) -
                      $signed({r_ent.minimum[15], r_ent.minimum});
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_n}) * r_diff;
        end
    end

    // Round to nearest, floor shift, offset by minimum
    assign rounded = $signed({r_prod[33], r_prod}) + 35'sd16384;
    assign scaled  = rounded >>> 15;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.target_param <= r_ent.param;
            r_out_item.target_value <= r_ent.minimum + $signed(scaled[15:0]);
        end
    end

    // Status to controller
    always_comb begin
        o_status.event_go = (i_in_item.func == mcm_pkg::FUNC_EVENT) &&
                            (i_in_item.kind != mcm_pkg::KIND_OTHER) &&
                            (count_eff != '0);
        o_status.match    = (r_ent.channel == r_chan) && (r_ent.number == r_num) &&
                            (r_ent.is_note == r_is_note);
        o_status.last     = ((r_idx + CW'(1)) == count_eff);
        o_status.blocked  = set_flag && (pick_mag > {1'b0, r_pickup_tol});
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* src/midi_control_mapper_core.sv */
`timescale 1ns / 1ps

// MIDI control mapper.
// Input channel (i_in_valid / o_in_stall / i_in_item) carries load items, which
// write one mapping slot, and MIDI event items. Output channel (o_out_valid /
// i_out_stall / o_out_item) carries at most one result per event: the target
// parameter and its scaled value. Registers are written on i_cfg_wr_en with
// i_cfg_index and i_cfg_wr_data; the user must write them only while the
// block is idle, as the block itself does not enforce this. A load item
// leaves the block ready again the next cycle. An event searches slots from
// zero upward through ST_READ (registered table read) and ST_CHECK (compare);
// a match goes on through ST_NORM, ST_MUL and ST_SCALE for normalizing, the
// multiply and the final scaling, unless the pickup check in ST_NORM blocks
// it, which ends the event with no result. Reset clears the pickup flags, the
// entries-in-use register and the output valid and sets the pickup tolerance
// to TOL_RESET; mapping slots hold garbage until loaded. A result waiting
// under i_out_stall does not block new items; a second result waits in its
// last step until the output register frees up, and the input stalls meanwhile.

module midi_control_mapper_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mcm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mcm_pkg::t_out_item o_out_item,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_wr_data
);

    mcm_pkg::t_dp_cmd    cmd;
    mcm_pkg::t_dp_status status;

    // Sequencer
    mcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Table, arithmetic and output register
    mcm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_item     (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

endmodule

/* src/mcm_chk.sv */
`timescale 1ns / 1ps

module mcm_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mcm_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mcm_pkg::t_out_item o_out_item
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // Loads and other messages leave the input ready in the next cycle
    a_quick_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall &&
         ((i_in_item.func == mcm_pkg::FUNC_LOAD) ||
          (i_in_item.kind == mcm_pkg::KIND_OTHER))) |=> !o_in_stall)
        else $error("input busy after a load or other message");

    // A new result only comes out of an event in progress
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an event in progress");

endmodule

bind midi_control_mapper_core mcm_chk u_mcm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
